@@ hdl/fasta_to_2bit_packer_core_assert.svh @@
// assertion macros used by the checker file
`ifndef FASTA_TO_2BIT_PACKER_CORE_ASSERT_SVH
`define FASTA_TO_2BIT_PACKER_CORE_ASSERT_SVH

// checked only outside reset
`define F2B_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define F2B_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ hdl/f2b_pkg.sv @@
// ----------------------------------------------------------------------------
// f2b_pkg
// Types and character constants for the FASTA to 2-bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package f2b_pkg;

  localparam int FIELD_W = 40;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_TARGET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 1'd1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] UPCASE_MASK = 8'hDF;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [2:0] BASES_FULL = 3'd4;

  typedef enum logic [2:0] {
    CLS_HEADER,
    CLS_SPACE,
    CLS_MARKER,
    CLS_BASE,
    CLS_INVALID
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [1:0] code;
    logic       newline;
  } cls_info_t;

endpackage

`default_nettype wire

@@ hdl/fasta_to_2bit_packer_core.sv @@
// ----------------------------------------------------------------------------
// fasta_to_2bit_packer_core
// FASTA text to 2-bit nucleotide packer with skip counters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one text byte or an end marker per
// transfer. Bases A/C/G/T in either case pack four to a byte, first base in
// bits 7:6. Each full byte gives one result; the end marker gives a final
// result with any partial byte, the five saturating counters and the
// mismatch flag against the expected base count when check_enable is set.
// A result is registered: it is on out_* in the cycle after the transfer that caused it.
// Throughput: one byte per cycle; in_ready stays high while the single output
// register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken.
// Reset clears stream state, counters and the config registers and empties
// the output register. After the end marker the stream state returns to reset
// values while the config registers are kept.
// Config writes (cfg_we) take effect at once; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fasta_to_2bit_packer_core #(
  parameter int COUNT_BITS = 40
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [f2b_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [f2b_pkg::FIELD_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_end_marker,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_packed_byte,
  output logic [2:0]                          out_bases_in_byte,
  output logic                                out_final_result,
  output logic [f2b_pkg::FIELD_W-1:0]         out_base_total,
  output logic [f2b_pkg::FIELD_W-1:0]         out_header_count,
  output logic [f2b_pkg::FIELD_W-1:0]         out_whitespace_count,
  output logic [f2b_pkg::FIELD_W-1:0]         out_marker_skip_count,
  output logic [f2b_pkg::FIELD_W-1:0]         out_invalid_count,
  output logic                                out_count_mismatch
);
  import f2b_pkg::*;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input cnt_t c);
    logic [63:0] ext;
    ext = 64'(c);
    return ext[FIELD_W-1:0];
  endfunction

  cls_info_t          info;
  logic [FIELD_W-1:0] expected_r;
  logic               check_en_r;

  logic       in_header_r, in_header_nxt;
  logic [7:0] pack_buf_r, pack_buf_nxt;
  logic [1:0] pack_fill_r, pack_fill_nxt;
  cnt_t       base_cnt_r, base_cnt_nxt;
  cnt_t       hdr_cnt_r, hdr_cnt_nxt;
  cnt_t       space_cnt_r, space_cnt_nxt;
  cnt_t       mark_cnt_r, mark_cnt_nxt;
  cnt_t       inv_cnt_r, inv_cnt_nxt;
  logic [7:0] merged_buf;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [2:0]          out_n_r, out_n_nxt;
  logic                out_fin_r, out_fin_nxt;
  logic                out_mis_r, out_mis_nxt;
  logic [FIELD_W-1:0]  out_base_r, out_hdr_r, out_space_r, out_mark_r, out_inv_r;
  logic                in_xfer;
  logic                emit;

  f2b_classify u_cls (
    .byte_i (in_byte),
    .info_o (info)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign merged_buf = pack_buf_r | (8'({info.code, 6'b0}) >> {pack_fill_r, 1'b0});

  always_comb begin
    in_header_nxt = in_header_r;
    pack_buf_nxt  = pack_buf_r;
    pack_fill_nxt = pack_fill_r;
    base_cnt_nxt  = base_cnt_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    space_cnt_nxt = space_cnt_r;
    mark_cnt_nxt  = mark_cnt_r;
    inv_cnt_nxt   = inv_cnt_r;
    emit          = 1'b0;
    out_byte_nxt  = pack_buf_r;
    out_n_nxt     = {1'b0, pack_fill_r};
    out_fin_nxt   = 1'b0;
    out_mis_nxt   = 1'b0;
    if (in_end_marker) begin
      emit          = 1'b1;
      out_fin_nxt   = 1'b1;
      out_mis_nxt   = check_en_r && (64'(base_cnt_r) != 64'(expected_r));
      in_header_nxt = 1'b0;
      pack_buf_nxt  = '0;
      pack_fill_nxt = '0;
      base_cnt_nxt  = '0;
      hdr_cnt_nxt   = '0;
      space_cnt_nxt = '0;
      mark_cnt_nxt  = '0;
      inv_cnt_nxt   = '0;
    end else if (in_header_r) begin
      if (info.newline) begin
        in_header_nxt = 1'b0;
      end
    end else begin
      case (info.cls)
        CLS_HEADER: begin
          hdr_cnt_nxt   = sat_inc(hdr_cnt_r);
          in_header_nxt = 1'b1;
        end
        CLS_SPACE:  space_cnt_nxt = sat_inc(space_cnt_r);
        CLS_MARKER: mark_cnt_nxt  = sat_inc(mark_cnt_r);
        CLS_BASE: begin
          base_cnt_nxt = sat_inc(base_cnt_r);
          if (&pack_fill_r) begin
            emit          = 1'b1;
            out_byte_nxt  = merged_buf;
            out_n_nxt     = BASES_FULL;
            pack_buf_nxt  = '0;
            pack_fill_nxt = '0;
          end else begin
            pack_buf_nxt  = merged_buf;
            pack_fill_nxt = pack_fill_r + 2'd1;
          end
        end
        default: inv_cnt_nxt = sat_inc(inv_cnt_r);
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      check_en_r  <= 1'b0;
      in_header_r <= 1'b0;
      pack_buf_r  <= '0;
      pack_fill_r <= '0;
      base_cnt_r  <= '0;
      hdr_cnt_r   <= '0;
      space_cnt_r <= '0;
      mark_cnt_r  <= '0;
      inv_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_TARGET:  expected_r <= cfg_data;
          REG_CHECK_ENABLE: check_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        in_header_r <= in_header_nxt;
        pack_buf_r  <= pack_buf_nxt;
        pack_fill_r <= pack_fill_nxt;
        base_cnt_r  <= base_cnt_nxt;
        hdr_cnt_r   <= hdr_cnt_nxt;
        space_cnt_r <= space_cnt_nxt;
        mark_cnt_r  <= mark_cnt_nxt;
        inv_cnt_r   <= inv_cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload; counters include the transferred byte, and an end marker reports them before it clears them
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_byte_r  <= out_byte_nxt;
      out_n_r     <= out_n_nxt;
      out_fin_r   <= out_fin_nxt;
      out_mis_r   <= out_mis_nxt;
      out_base_r  <= in_end_marker ? to_field(base_cnt_r)  : to_field(base_cnt_nxt);
      out_hdr_r   <= to_field(hdr_cnt_r);
      out_space_r <= to_field(space_cnt_r);
      out_mark_r  <= to_field(mark_cnt_r);
      out_inv_r   <= to_field(inv_cnt_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_packed_byte       = out_byte_r;
  assign out_bases_in_byte     = out_n_r;
  assign out_final_result      = out_fin_r;
  assign out_count_mismatch    = out_mis_r;
  assign out_base_total        = out_base_r;
  assign out_header_count      = out_hdr_r;
  assign out_whitespace_count  = out_space_r;
  assign out_marker_skip_count = out_mark_r;
  assign out_invalid_count     = out_inv_r;

endmodule

`default_nettype wire

@@ hdl/f2b_classify.sv @@
// ----------------------------------------------------------------------------
// f2b_classify
// Sorts one text byte into header open, whitespace, marker, base or invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module f2b_classify (
  input  wire logic [7:0]         byte_i,
  output f2b_pkg::cls_info_t      info_o
);
  import f2b_pkg::*;

  logic [7:0] upper;

  always_comb begin
    upper = byte_i & UPCASE_MASK;
    info_o.newline = (byte_i == CH_NL);
    info_o.code = BASE_A;
    if (byte_i == CH_GT) begin
      info_o.cls = CLS_HEADER;
    end else if (byte_i == CH_SPACE || (byte_i >= CH_TAB && byte_i <= CH_CR)) begin
      info_o.cls = CLS_SPACE;
    end else if (byte_i == CH_DOLLAR || byte_i == CH_NUL) begin
      info_o.cls = CLS_MARKER;
    end else if (upper == CH_A) begin
      info_o.cls = CLS_BASE;
    end else if (upper == CH_C) begin
      info_o.cls = CLS_BASE;
      info_o.code = BASE_C;
    end else if (upper == CH_G) begin
      info_o.cls = CLS_BASE;
      info_o.code = BASE_G;
    end else if (upper == CH_T) begin
      info_o.cls = CLS_BASE;
      info_o.code = BASE_T;
    end else begin
      info_o.cls = CLS_INVALID;
    end
  end

endmodule

`default_nettype wire

@@ hdl/f2b_port_check.sv @@
// ----------------------------------------------------------------------------
// f2b_port_check
// Port-level checks for the packer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fasta_to_2bit_packer_core_assert.svh"

module f2b_port_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_packed_byte,
  input wire logic [2:0] out_bases_in_byte,
  input wire logic       out_final_result,
  input wire logic       out_count_mismatch
);

  // result holds until taken
  `F2B_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_packed_byte))
  // a full byte always carries four bases and no mismatch
  `F2B_ASSERT(a_full_byte, out_valid && !out_final_result |-> out_bases_in_byte == 3'd4 && !out_count_mismatch)
  // empty output register never blocks input
  `F2B_ASSERT(a_ready_free, !out_valid |-> in_ready)
  // reset empties the output register
  `F2B_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

endmodule

bind fasta_to_2bit_packer_core f2b_port_check u_port_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_packed_byte    (out_packed_byte),
  .out_bases_in_byte  (out_bases_in_byte),
  .out_final_result   (out_final_result),
  .out_count_mismatch (out_count_mismatch)
);

`default_nettype wire
